@@ rtl/first_fit_block_allocator_unit_macros.svh @@
// assertion macros used by the allocator top level
// no dependencies
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define FFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m failed");
`define FFA_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m failed");
`endif

@@ rtl/ffa_pkg.sv @@
// types and constants of the first fit block allocator
// no dependencies
`default_nettype none
package ffa_pkg;
  localparam int MaxBlocks   = 64;
  localparam int HeaderBytes = 24;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StNull    = 3'd1;
  localparam logic [2:0] StNoMem   = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StUnknown = 3'd4;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  localparam logic CfgBase = 1'b0;
  localparam logic CfgSize = 1'b1;

  typedef struct packed {
    logic        action;
    logic [23:0] request_size;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] free_bytes;
    logic [31:0] used_bytes;
  } rsp_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
    logic        is_free;
  } entry_t;
endpackage
`default_nettype wire

@@ rtl/first_fit_block_allocator_unit.sv @@
// first fit heap allocator with coalescing, top level
// depends on ffa_pkg, ffa_table_ram and the assertion macro header
// req: req_valid_i / req_stall_o carry an allocate or free transaction
// rsp: rsp_valid_o / rsp_stall_i carry exactly one result per request
// cfg: cfg_valid_i / cfg_ready_o write heap_base (0) or heap_size (1);
//   any write empties the table and returns the top to the base
// the table sits in a ram with one write and one registered read port,
//   so a table walk sets the address of each entry, then takes its data
// allocate: a search of the table; a split shifts the later entries
//   up one place, then writes the split pair
// free: a lookup, then a merge sweep over the table in which each merge
//   moves the later entries down; at most two merges
// null and zero size requests answer in the cycle after acceptance
// one request at a time; the next is taken once the result has left
// reset: count and top go to zero, no clearing pass as only entries
//   below the count are read
// stalls: the result sits in an output register; while rsp_stall_i is
//   high the block holds it and takes no new transaction
`default_nettype none
`include "first_fit_block_allocator_unit_macros.svh"
module first_fit_block_allocator_unit import ffa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_stall_o,
  input  wire req_t        req_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_stall_i,
  output rsp_t             rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRD   = 10'b0000000010, // search read wait
    S_SCHK  = 10'b0000000100, // search compare
    S_SHRD  = 10'b0000001000, // shift-up read wait
    S_SHWR  = 10'b0000010000, // shift-up write
    S_FIN   = 10'b0000100000, // write split pair
    S_MRD   = 10'b0001000000, // merge read wait
    S_MCHK  = 10'b0010000000, // merge compare
    S_MVRD  = 10'b0100000000, // move down read wait
    S_MVWR  = 10'b1000000000  // move down write
  } state_e;

  state_e          state_q, state_d;
  logic [31:0]     base_q, size_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [32:0]     top_q, top_d;
  req_t            req_q;
  logic [CntW-1:0] idx_q, idx_d;     // walk index
  logic [CntW-1:0] hit_q, hit_d;     // found entry / merge base
  entry_t          cur_q, cur_d;     // held entry
  logic            prev_q, prev_d;   // a held entry is valid (merge)
  logic [CntW-1:0] mv_q, mv_d;       // move pointer
  logic            rsp_v_q;
  rsp_t            rsp_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic            done;
  logic [31:0]     res_addr;
  logic [2:0]      res_st;

  ffa_table_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // rounded size, 33 bits covers the sum with the header
  logic [32:0] need;
  assign need = ({9'd0, req_q.request_size} + 33'd7) & ~33'd7;

  assign req_stall_o = (state_q != S_IDLE) || rsp_v_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  logic [32:0] new_top;
  assign new_top = top_q + need + 33'(HeaderBytes);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; top_d = top_q;
    idx_d = idx_q; hit_d = hit_q; cur_d = cur_q; prev_d = prev_q; mv_d = mv_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_q[IdxW-1:0];
    done = 1'b0; res_addr = '0; res_st = StOk;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        prev_d = 1'b0;
        if (req_valid_i && !req_stall_o) begin
          if (req_i.action == ActAlloc && req_i.request_size == '0) begin
            done = 1'b1; res_st = StNull;
          end else if (req_i.action == ActFree && req_i.free_address == '0) begin
            done = 1'b1; res_st = StNull;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (idx_q >= cnt_q) begin
          // walk exhausted
          if (req_q.action == ActFree) begin
            done = 1'b1; res_st = StUnknown; state_d = S_IDLE;
          end else if (new_top > {1'b0, size_q}) begin
            done = 1'b1; res_st = StNoMem; state_d = S_IDLE;
          end else if (cnt_q >= CntW'(MaxBlocks)) begin
            done = 1'b1; res_st = StFull; state_d = S_IDLE;
          end else begin
            we = 1'b1; waddr = cnt_q[IdxW-1:0];
            wdata = '{offset: top_q[31:0], length: need[31:0], is_free: 1'b0};
            cnt_d = cnt_q + 1'b1; top_d = new_top;
            done = 1'b1;
            res_addr = base_q + top_q[31:0] + 32'(HeaderBytes);
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (req_q.action == ActFree) begin
          if (base_q + rdata.offset + 32'(HeaderBytes) == req_q.free_address) begin
            we = 1'b1; waddr = idx_q[IdxW-1:0];
            wdata = '{offset: rdata.offset, length: rdata.length, is_free: 1'b1};
            idx_d = '0; prev_d = 1'b0; state_d = S_MRD;
          end else begin
            idx_d = idx_q + 1'b1; state_d = S_SRD;
          end
        end else if (rdata.is_free && {1'b0, rdata.length} >= need) begin
          hit_d = idx_q; cur_d = rdata;
          if ({1'b0, rdata.length} >= need + 33'(HeaderBytes + 16)
              && cnt_q < CntW'(MaxBlocks)) begin
            mv_d = cnt_q; state_d = S_SHRD;
          end else begin
            we = 1'b1; waddr = idx_q[IdxW-1:0];
            wdata = '{offset: rdata.offset, length: rdata.length, is_free: 1'b0};
            done = 1'b1;
            res_addr = base_q + rdata.offset + 32'(HeaderBytes);
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_SRD;
        end
      end
      S_SHRD: begin
        // move entry mv-1 to mv for mv > hit+1
        if (mv_q > hit_q + 1'b1) begin
          raddr = IdxW'(mv_q - 1'b1);
          state_d = S_SHWR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SHWR: begin
        we = 1'b1; waddr = mv_q[IdxW-1:0]; wdata = rdata;
        mv_d = mv_q - 1'b1; state_d = S_SHRD;
      end
      S_FIN: begin
        // two writes: tail first, then the taken head next cycle
        we = 1'b1; waddr = IdxW'(hit_q + 1'b1);
        wdata = '{offset: cur_q.offset + 32'(HeaderBytes) + need[31:0],
                  length: cur_q.length - need[31:0] - 32'(HeaderBytes),
                  is_free: 1'b1};
        cnt_d = cnt_q + 1'b1;
        cur_d.length = need[31:0]; cur_d.is_free = 1'b0;
        state_d = S_MVWR; mv_d = '0; prev_d = 1'b1;
      end
      S_MRD: begin
        if (idx_q >= cnt_q) begin
          if (prev_q) begin
            we = 1'b1; waddr = hit_q[IdxW-1:0]; wdata = cur_q;
          end
          done = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        if (prev_q && cur_q.is_free && rdata.is_free) begin
          // absorb entry idx into held entry, then close the gap
          cur_d.length = cur_q.length + rdata.length + 32'(HeaderBytes);
          mv_d = idx_q; state_d = S_MVRD;
        end else begin
          if (prev_q) begin
            we = 1'b1; waddr = hit_q[IdxW-1:0]; wdata = cur_q;
          end
          hit_d = idx_q; cur_d = rdata; prev_d = 1'b1;
          idx_d = idx_q + 1'b1; state_d = S_MRD;
        end
      end
      S_MVRD: begin
        if (mv_q + 1'b1 < cnt_q) begin
          raddr = IdxW'(mv_q + 1'b1);
          state_d = S_MVWR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_MRD;
        end
      end
      S_MVWR: begin
        if (req_q.action == ActAlloc) begin
          // head of a split allocation
          we = 1'b1; waddr = hit_q[IdxW-1:0]; wdata = cur_q;
          done = 1'b1;
          res_addr = base_q + cur_q.offset + 32'(HeaderBytes);
          state_d = S_IDLE;
        end else begin
          we = 1'b1; waddr = mv_q[IdxW-1:0]; wdata = rdata;
          mv_d = mv_q + 1'b1; state_d = S_MVRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a register write empties the table
    if (cfg_valid_i && cfg_ready_o) begin
      cnt_d = '0; top_d = '0;
    end
  end

  logic [32:0] fin_top;
  assign fin_top = top_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; top_q <= '0;
      base_q <= '0; size_q <= '0; rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; top_q <= top_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgBase) base_q <= cfg_data_i;
        else                        size_q <= cfg_data_i;
      end
      if (done) rsp_v_q <= 1'b1;
      else if (!rsp_stall_i) rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; hit_q <= hit_d; cur_q <= cur_d; prev_q <= prev_d; mv_q <= mv_d;
    if (req_valid_i && !req_stall_o) req_q <= req_i;
    if (done) begin
      rsp_q.result_address <= res_addr;
      rsp_q.status         <= res_st;
      rsp_q.free_bytes     <= (fin_top >= {1'b0, size_q}) ? 32'd0
                              : size_q - fin_top[31:0];
      rsp_q.used_bytes     <= fin_top[31:0];
    end
  end

  `FFA_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= CntW'(MaxBlocks))
  `FFA_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_v_q && rsp_stall_i |=> rsp_v_q && $stable(rsp_q))
  `FFA_ASSERT(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE |-> req_stall_o)
  `FFA_ASSERT(a_done_idle, clk_i, rst_ni, done |=> state_q == S_IDLE)
endmodule
`default_nettype wire

@@ rtl/ffa_table_ram.sv @@
// block table memory, one write and one registered read port
// depends on ffa_pkg
`default_nettype none
module ffa_table_ram import ffa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IdxW-1:0]    waddr_i,
  input  wire entry_t             wdata_i,
  input  wire logic [IdxW-1:0]    raddr_i,
  output entry_t                  rdata_o
);
  entry_t mem_q [MaxBlocks];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the first fit block allocator
// depends on ffa_pkg and the first_fit_block_allocator_unit rtl
// a scoreboard class predicts each result from its own heap table

module testbench;
  import ffa_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  // prediction of the allocator and the store of pending results
  class heap_scoreboard;
    bit [31:0] base, size;
    bit [31:0] offs [MaxBlocks];
    bit [31:0] lens [MaxBlocks];
    bit        frees [MaxBlocks];
    int unsigned count;
    longint unsigned top;
    rsp_t pending_rsp [$];
    int unsigned errors;

    function void clear_heap();
      count = 0;
      top = 0;
    endfunction

    function void configure(logic idx, bit [31:0] data);
      if (idx == CfgBase) base = data;
      else size = data;
      clear_heap();
    endfunction

    function bit [31:0] payload(int unsigned k);
      return base + offs[k] + HeaderBytes;
    endfunction

    function bit [31:0] allocate(longint unsigned req, output logic [2:0] st);
      longint unsigned need;
      if (req == 0) begin
        st = StNull;
        return 0;
      end
      need = (req + 7) & ~64'd7;
      for (int unsigned i = 0; i < count; i++) begin
        if (frees[i] && lens[i] >= need) begin
          frees[i] = 0;
          // split only when the surplus holds a header and a minimal payload
          if (lens[i] >= need + HeaderBytes + 16 && count < MaxBlocks) begin
            for (int unsigned j = count; j > i + 1; j--) begin
              offs[j] = offs[j-1];
              lens[j] = lens[j-1];
              frees[j] = frees[j-1];
            end
            offs[i+1] = offs[i] + HeaderBytes + need[31:0];
            lens[i+1] = lens[i] - need[31:0] - HeaderBytes;
            frees[i+1] = 1;
            lens[i] = need[31:0];
            count++;
          end
          st = StOk;
          return payload(i);
        end
      end
      if (top + need + HeaderBytes > size) begin
        st = StNoMem;
        return 0;
      end
      if (count >= MaxBlocks) begin
        st = StFull;
        return 0;
      end
      offs[count] = top[31:0];
      lens[count] = need[31:0];
      frees[count] = 0;
      count++;
      top += need + HeaderBytes;
      st = StOk;
      return payload(count - 1);
    endfunction

    function logic [2:0] release_block(bit [31:0] addr);
      int k;
      int unsigned i;
      k = -1;
      if (addr == 0) return StNull;
      for (int unsigned n = 0; n < count; n++)
        if (k < 0 && payload(n) == addr) k = n;
      if (k < 0) return StUnknown;
      frees[k] = 1;
      i = 0;
      while (i + 1 < count) begin
        if (frees[i] && frees[i+1]) begin
          lens[i] = lens[i] + lens[i+1] + HeaderBytes;
          for (int unsigned j = i + 1; j + 1 < count; j++) begin
            offs[j] = offs[j+1];
            lens[j] = lens[j+1];
            frees[j] = frees[j+1];
          end
          count--;
        end else begin
          i++;
        end
      end
      return StOk;
    endfunction

    // accepted request: work out its result and queue it
    function rsp_t note_request(req_t r);
      rsp_t e;
      e.result_address = 0;
      if (r.action == ActAlloc) e.result_address = allocate(r.request_size, e.status);
      else e.status = release_block(r.free_address);
      e.free_bytes = (top >= size) ? 32'd0 : size - top[31:0];
      e.used_bytes = top[31:0];
      pending_rsp.push_back(e);
      return e;
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.result_address !== e.result_address) begin
        $display("%0t: result_address exp %h got %h", $time, e.result_address,
                 a.result_address);
        errors++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.free_bytes !== e.free_bytes) begin
        $display("%0t: free_bytes exp %h got %h", $time, e.free_bytes, a.free_bytes);
        errors++;
      end
      if (a.used_bytes !== e.used_bytes) begin
        $display("%0t: used_bytes exp %h got %h", $time, e.used_bytes, a.used_bytes);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_stall_o;
  req_t        req_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 1'b0;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgBase;
  logic [31:0] cfg_data_i = '0;

  first_fit_block_allocator_unit uut (.*);

  heap_scoreboard sb = new();
  int unsigned send_idle_pct, recv_stall_pct, hold_cycles, cycle_count;
  bit [31:0] live_addr [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check accepted transactions, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i) sb.check_result(rsp_o);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_request(req_t r);
    rsp_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (req_stall_o);
    e = sb.note_request(r);
    // remember live payloads so that frees mostly hit real blocks
    if (r.action == ActAlloc && e.status == StOk) live_addr.push_back(e.result_address);
  endtask

  task automatic alloc(int unsigned sz);
    req_t r;
    r = '0;
    r.action = ActAlloc;
    r.request_size = 24'(sz);
    r.free_address = $urandom();
    send_request(r);
  endtask

  task automatic free_addr(bit [31:0] a);
    req_t r;
    r.action = ActFree;
    r.request_size = 24'($urandom());
    r.free_address = a;
    send_request(r);
  endtask

  // wait until idle, then rewrite both registers
  task automatic set_heap(bit [31:0] b, bit [31:0] s);
    @(posedge clk_i);
    req_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? CfgBase : CfgSize;
      cfg_data_i <= (i == 0) ? b : s;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.configure((i == 0) ? CfgBase : CfgSize, (i == 0) ? b : s);
    end
    cfg_valid_i <= 1'b0;
    live_addr.delete();
  endtask

  task automatic random_items(int unsigned n);
    int unsigned pick, k, sz;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // mostly small sizes, now and then a large or wild one
        k = $urandom_range(99);
        if (k < 80) sz = $urandom_range(256, 1);
        else if (k < 95) sz = $urandom_range(4096, 1);
        else sz = $urandom() & 24'hffffff;
        alloc(sz);
      end else if (pick < 92 && live_addr.size() != 0) begin
        k = $urandom_range(live_addr.size() - 1);
        free_addr(live_addr[k]);
        // occasionally leave it listed so a double free follows
        if ($urandom_range(9) != 0) live_addr.delete(k);
      end else begin
        k = $urandom_range(2);
        if (k == 0) free_addr(32'd0);
        else if (k == 1) free_addr($urandom());
        else free_addr(live_addr.size() ? live_addr[0] + 8 : $urandom());
      end
    end
  endtask

  task automatic set_mode(int unsigned m);
    case (m % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
      default: begin send_idle_pct = 31; recv_stall_pct = 31; end
    endcase
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: null cases, out of memory, unknown and double free, split
    set_heap(32'h0000_1000, 32'h0001_0000);
    alloc(0);
    free_addr(32'd0);
    alloc(24'hffffff);
    free_addr(32'hffff_ffff);
    alloc(1);
    alloc(100);
    alloc(16);
    free_addr(32'h0000_1000 + 24 + 8 + 24);
    free_addr(32'h0000_1000 + 24 + 8 + 24);
    alloc(8);
    alloc(40);
    free_addr(32'h0000_1018);
    free_addr(32'h0000_1018 + 8);
    // table full on carve
    set_heap(32'd0, 32'hffff_ffff);
    for (int i = 0; i < MaxBlocks + 1; i++) alloc(8);
    // zero length heap, then the top extreme of the base
    set_heap(32'hffff_ffff, 32'd0);
    alloc(1);
    free_addr(32'h0000_0017);
    set_heap(32'hffff_ffff, 32'd1);
    alloc(1);

    // random phases across heap settings and idling modes
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: set_heap(32'h0000_1000, 32'h0000_1000);
        1: set_heap(32'd0, 32'hffff_ffff);
        2: set_heap(32'hffff_0000, 32'h0000_ffff);
        default: set_heap($urandom(), 32'h0000_4000);
      endcase
      set_mode(p);
      // long hold-off on the result side so the request side backs up
      if (p == 4) hold_cycles = 2000;
      random_items(135);
    end

    @(posedge clk_i);
    req_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
